/* rtl/exbp_pkg.sv */
// shared types and constants for the exponential brightness to dual pwm block
// no dependencies; imported by every module of the block
`default_nettype none

package exbp_pkg;

  // fixed point formats
  localparam int unsigned FRAC_BITS  = 20;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned SCALE_W    = 25;
  localparam int unsigned PROD_W     = LEVEL_W + SCALE_W;
  localparam int unsigned IP_W       = PROD_W - FRAC_BITS;
  localparam int unsigned CURVE_W    = 18;
  localparam int unsigned DIFF_W     = 17;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned MANT_FRAC  = 16;
  localparam int unsigned SAT_SHIFT  = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  // register reset values
  localparam logic [LEVEL_W-1:0] MAX_IN_RST    = 16'd1;
  localparam logic [SCALE_W-1:0] EXP_SCALE_RST = 25'd17825780;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_IN    = 2'd0,
    CFG_EXP_SCALE = 2'd1
  } cfg_idx_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [LEVEL_W-1:0] max_in;
    logic [SCALE_W-1:0] exp_scale;
  } cfg_t;

  // exponent split into integer and fractional parts
  typedef struct packed {
    logic                 valid;
    logic [IP_W-1:0]      ip;
    logic [FRAC_BITS-1:0] frac;
  } exp_stage_t;

  // interpolation operands and shift control
  typedef struct packed {
    logic                 valid;
    logic                 sat;
    logic [SHIFT_W-1:0]   shift;
    logic [CURVE_W-1:0]   base;
    logic [DIFF_W-1:0]    diff;
    logic [FRAC_BITS-1:0] weight;
  } interp_stage_t;

  // interpolated mantissa parts ready for the final shift
  typedef struct packed {
    logic               valid;
    logic               sat;
    logic [SHIFT_W-1:0] shift;
    logic [CURVE_W-1:0] base;
    logic [DIFF_W-1:0]  delta;
  } mant_stage_t;

endpackage

`default_nettype wire

/* rtl/exbp_cfg_regs.sv */
// configuration registers max_in and exp_scale behind a valid/ready write port
// depends on exbp_pkg
`default_nettype none

module exbp_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [exbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [exbp_pkg::SCALE_W-1:0]    cfg_data_i,
  output      exbp_pkg::cfg_t                  cfg_o
);
  import exbp_pkg::*;

  logic [LEVEL_W-1:0] max_in_q, max_in_d;
  logic [SCALE_W-1:0] exp_scale_q, exp_scale_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    max_in_d    = max_in_q;
    exp_scale_d = exp_scale_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_IN:    max_in_d    = cfg_data_i[LEVEL_W-1:0];
        CFG_EXP_SCALE: exp_scale_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_in_q    <= MAX_IN_RST;
      exp_scale_q <= EXP_SCALE_RST;
    end else begin
      max_in_q    <= max_in_d;
      exp_scale_q <= exp_scale_d;
    end
  end

  assign cfg_o.max_in    = max_in_q;
  assign cfg_o.exp_scale = exp_scale_q;

endmodule

`default_nettype wire

/* rtl/exbp_exponent.sv */
// stages 1-2: clamp the request, then multiply by exp_scale into a q.20 exponent
// depends on exbp_pkg
`default_nettype none

module exbp_exponent (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  input  wire logic [exbp_pkg::LEVEL_W-1:0]  level_request_i,
  input  wire exbp_pkg::cfg_t                cfg_i,
  output      exbp_pkg::exp_stage_t          exp_o
);
  import exbp_pkg::*;

  logic               lvl_valid_q;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;
  logic [PROD_W-1:0]  prod;
  logic               exp_valid_q;
  logic [PROD_W-1:0]  prod_q;

  // clamp to max_in
  always_comb begin
    lvl_d = level_request_i;
    if (level_request_i > cfg_i.max_in) begin
      lvl_d = cfg_i.max_in;
    end
  end

  assign prod = PROD_W'(lvl_q) * PROD_W'(cfg_i.exp_scale);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_valid_q <= 1'b0;
      exp_valid_q <= 1'b0;
    end else begin
      lvl_valid_q <= req_valid_i;
      exp_valid_q <= lvl_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    prod_q <= prod;
  end

  assign exp_o.valid = exp_valid_q;
  assign exp_o.ip    = prod_q[PROD_W-1:FRAC_BITS];
  assign exp_o.frac  = prod_q[FRAC_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/exbp_interp.sv */
// stages 3-4: curve table lookup, then slope times weight for linear interpolation
// depends on exbp_pkg; the q16 table of 2^(k/n) is built at elaboration
`default_nettype none

module exbp_interp #(
  parameter int unsigned EXP_TABLE_SIZE = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire exbp_pkg::exp_stage_t   exp_i,
  output      exbp_pkg::mant_stage_t  mant_o
);
  import exbp_pkg::*;

  localparam int unsigned TIDX_W  = $clog2(EXP_TABLE_SIZE + 1);
  localparam int unsigned P_W     = FRAC_BITS + TIDX_W;
  localparam int unsigned ROOTS   = 30;
  localparam int unsigned MUL_W   = DIFF_W + FRAC_BITS;

  typedef logic [CURVE_W-1:0] curve_arr_t [EXP_TABLE_SIZE+1];

  // bitwise integer square root
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] vv;
    res = 64'd0;
    bt  = 64'h4000_0000_0000_0000;
    vv  = v;
    while (bt > vv) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (vv >= res + bt) begin
        vv  = vv - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(k/n) in q16 from a product of repeated square roots of two
  function automatic curve_arr_t build_curve();
    curve_arr_t  c;
    logic [63:0] roots [ROOTS+1];
    logic [63:0] x;
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    for (int j = 1; j <= ROOTS; j++) begin
      roots[j] = isqrt(roots[j-1] << 30);
    end
    for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
      x   = (64'(k) << 30) / EXP_TABLE_SIZE;
      acc = 64'd1 << 30;
      for (int j = 1; j <= ROOTS; j++) begin
        if (x[ROOTS-j]) begin
          acc = (acc * roots[j] + (64'd1 << 29)) >> 30;
        end
      end
      c[k] = CURVE_W'((acc + (64'd1 << 13)) >> 14);
    end
    c[0]              = CURVE_W'(65536);
    c[EXP_TABLE_SIZE] = CURVE_W'(131072);
    return c;
  endfunction

  localparam curve_arr_t CURVE = build_curve();

  logic [P_W-1:0]     pos;
  logic [TIDX_W-1:0]  idx_lo, idx_hi;
  logic [CURVE_W-1:0] t_lo, t_hi;
  interp_stage_t      ip_d, ip_q;
  logic [MUL_W-1:0]   slope_prod;
  mant_stage_t        mant_d, mant_q;

  // table position from the exponent fraction
  assign pos    = P_W'(exp_i.frac) * P_W'(EXP_TABLE_SIZE);
  assign idx_lo = TIDX_W'(pos[P_W-1:FRAC_BITS]);
  assign idx_hi = idx_lo + TIDX_W'(1);
  assign t_lo   = CURVE[idx_lo];
  assign t_hi   = CURVE[idx_hi];

  always_comb begin
    ip_d.valid  = exp_i.valid;
    ip_d.sat    = (exp_i.ip >= IP_W'(SAT_SHIFT));
    ip_d.shift  = exp_i.ip[SHIFT_W-1:0];
    ip_d.base   = t_lo;
    ip_d.diff   = DIFF_W'(t_hi - t_lo);
    ip_d.weight = pos[FRAC_BITS-1:0];
  end

  // slope times weight
  assign slope_prod = MUL_W'(ip_q.diff) * MUL_W'(ip_q.weight);

  always_comb begin
    mant_d.valid = ip_q.valid;
    mant_d.sat   = ip_q.sat;
    mant_d.shift = ip_q.shift;
    mant_d.base  = ip_q.base;
    mant_d.delta = slope_prod[MUL_W-1:FRAC_BITS];
  end

  // stage registers with their valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q   <= '0;
      mant_q <= '0;
    end else begin
      ip_q   <= ip_d;
      mant_q <= mant_d;
    end
  end

  assign mant_o = mant_q;

endmodule

`default_nettype wire

/* rtl/exbp_scale_out.sv */
// stage 5: add mantissa parts, shift by the integer exponent, round, cap, split
// depends on exbp_pkg
`default_nettype none

module exbp_scale_out #(
  parameter int unsigned PWM_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire exbp_pkg::mant_stage_t  mant_i,
  output      logic                   result_valid_o,
  output      logic [PWM_BITS:0]      light_level_o,
  output      logic [PWM_BITS-1:0]    pwm_low_o,
  output      logic [PWM_BITS-1:0]    pwm_high_o
);
  import exbp_pkg::*;

  localparam int unsigned SH_W  = CURVE_W + MANT_FRAC + 1;
  localparam int unsigned VAL_W = SH_W - MANT_FRAC;
  localparam logic [PWM_BITS-1:0] PWM_FULL  = {PWM_BITS{1'b1}};
  localparam logic [PWM_BITS:0]   LEVEL_CAP = {PWM_FULL, 1'b0};

  logic [CURVE_W-1:0]  mant;
  logic [SH_W-1:0]     shifted;
  logic [VAL_W-1:0]    val_raw;
  logic [PWM_BITS:0]   val;
  logic                valid_q;
  logic [PWM_BITS:0]   light_q, light_d;
  logic [PWM_BITS-1:0] low_q, low_d;
  logic [PWM_BITS-1:0] high_q, high_d;

  // mantissa, shift and round half up
  assign mant    = mant_i.base + CURVE_W'(mant_i.delta);
  assign shifted = (SH_W'(mant) << mant_i.shift) + SH_W'(1 << (MANT_FRAC - 1));
  assign val_raw = shifted[SH_W-1:MANT_FRAC];

  // saturate at twice full duty
  always_comb begin
    if (mant_i.sat || (val_raw > VAL_W'(LEVEL_CAP))) begin
      val = LEVEL_CAP;
    end else begin
      val = val_raw[PWM_BITS:0];
    end
  end

  // split over the two channels
  always_comb begin
    light_d = val;
    if (val < {1'b0, PWM_FULL}) begin
      low_d  = val[PWM_BITS-1:0];
      high_d = '0;
    end else begin
      low_d  = PWM_FULL;
      high_d = PWM_BITS'(val - {1'b0, PWM_FULL});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= mant_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    light_q <= light_d;
    low_q   <= low_d;
    high_q  <= high_d;
  end

  assign result_valid_o = valid_q;
  assign light_level_o  = light_q;
  assign pwm_low_o      = low_q;
  assign pwm_high_o     = high_q;

endmodule

`default_nettype wire

/* rtl/exp_brightness_to_dual_pwm.sv */
// exponential brightness curve split over two pwm channels, top level
// start passes through five register stages (clamp, multiply, table lookup,
// interpolation, shift/split) to result_valid_o; one request per cycle, busy stays low
// async active-low reset clears valid bits and loads max_in = 1, exp_scale = 17825780
// results are strobed for one cycle; the receiver cannot stall
// depends on exbp_pkg, exbp_cfg_regs, exbp_exponent, exbp_interp, exbp_scale_out
`default_nettype none

module exp_brightness_to_dual_pwm #(
  parameter int unsigned EXP_TABLE_SIZE = 64,
  parameter int unsigned PWM_BITS       = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire logic [exbp_pkg::LEVEL_W-1:0]    level_request_i,
  output      logic                            result_valid_o,
  output      logic [PWM_BITS:0]               light_level_o,
  output      logic [PWM_BITS-1:0]             pwm_low_o,
  output      logic [PWM_BITS-1:0]             pwm_high_o,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [exbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [exbp_pkg::SCALE_W-1:0]    cfg_data_i
);
  import exbp_pkg::*;

  cfg_t        cfg;
  exp_stage_t  exp_st;
  mant_stage_t mant_st;

  // fully pipelined, a request is taken every cycle
  assign busy = 1'b0;

  exbp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  exbp_exponent u_exponent (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (start & ~busy),
    .level_request_i (level_request_i),
    .cfg_i           (cfg),
    .exp_o           (exp_st)
  );

  exbp_interp #(
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exp_i  (exp_st),
    .mant_o (mant_st)
  );

  exbp_scale_out #(
    .PWM_BITS (PWM_BITS)
  ) u_scale_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mant_i         (mant_st),
    .result_valid_o (result_valid_o),
    .light_level_o  (light_level_o),
    .pwm_low_o      (pwm_low_o),
    .pwm_high_o     (pwm_high_o)
  );

endmodule

`default_nettype wire
